>>> src/assert_macros.svh
// concurrent checks sampled on clk, off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> src/hmub_pkg.sv
package hmub_pkg;

  localparam int Q_BITS = 17;
  localparam logic [Q_BITS-1:0] UNITY_ONE = 17'd65536;

  typedef struct packed {
    logic [63:0] word;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic [16:0] unity;
    logic [63:0] consensus;
    logic [10:0] word_count;
    logic        overflow;
  } out_item_t;

  typedef struct packed {
    logic load_word;
    logic fin_start;
    logic den_load;
    logic sum_shift;
    logic acc_en;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

>>> src/hmub_ctrl.sv
module hmub_ctrl import hmub_pkg::*; #(
  parameter int WORD_BITS = 64
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_last,
  output logic    in_stall,
  input  status_t st,
  output cmd_t    cmd
);

  localparam int STEPS_MAX = (WORD_BITS > Q_BITS) ? WORD_BITS : Q_BITS;
  localparam int SCW = $clog2(STEPS_MAX + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_PAIR = 8'b0000_0010,
    S_DEN  = 8'b0000_0100,
    S_SUM  = 8'b0000_1000,
    S_ACC  = 8'b0001_0000,
    S_DIVI = 8'b0010_0000,
    S_DIV  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t         state_r, state_nxt;
  logic [SCW-1:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall      = 1'b0;
        cmd.load_word = in_valid;
        if (in_valid && in_last) begin
          state_nxt = S_PAIR;
        end
      end
      S_PAIR: begin
        cmd.fin_start = 1'b1;
        state_nxt     = S_DEN;
      end
      S_DEN: begin
        cmd.den_load = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_SUM;
      end
      S_SUM: begin
        cmd.sum_shift = 1'b1;
        cmd.acc_en    = (step_r != '0);
        if (step_r == SCW'(WORD_BITS - 1)) begin
          step_nxt  = '0;
          state_nxt = S_ACC;
        end else begin
          step_nxt = step_r + SCW'(1);
        end
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
        state_nxt  = S_DIVI;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == SCW'(Q_BITS - 1)) begin
          step_nxt  = '0;
          state_nxt = S_DONE;
        end else begin
          step_nxt = step_r + SCW'(1);
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        step_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

>>> src/hmub_datapath.sv
module hmub_datapath import hmub_pkg::*; #(
  parameter int WORD_BITS = 64,
  parameter int WORD_LIMIT = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  input  in_item_t  in_data,
  output status_t   st,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int NW   = $clog2(WORD_LIMIT + 1);
  localparam int DENW = 2 * NW + 6;
  localparam int REMW = DENW + 18;

  logic [NW-1:0]     cnt_r [WORD_BITS];
  logic [NW-1:0]     n_r;
  logic              drop_r;
  logic [2*NW-1:0]   prod_r;
  logic [DENW-1:0]   den_r;
  logic [DENW-1:0]   dist_r;
  logic [63:0]       cons_r;
  logic [63:0]       cons_nxt;
  logic [REMW-1:0]   rem_r;
  logic [REMW-1:0]   dv_r;
  logic [Q_BITS-1:0] q_r;
  logic              out_valid_r;
  out_item_t         out_r;
  logic [NW-1:0]     mul_a, mul_b;
  logic              ge;
  logic [31:0]       n_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WORD_BITS; i++) begin
        cnt_r[i] <= '0;
      end
      n_r    <= '0;
      drop_r <= 1'b0;
    end else if (cmd.load_word) begin
      if (n_r < NW'(WORD_LIMIT)) begin
        for (int i = 0; i < WORD_BITS; i++) begin
          cnt_r[i] <= cnt_r[i] + NW'(in_data.word[i]);
        end
        n_r <= n_r + NW'(1);
      end else begin
        drop_r <= 1'b1;
      end
    end else if (cmd.sum_shift) begin
      for (int i = 0; i < WORD_BITS - 1; i++) begin
        cnt_r[i] <= cnt_r[i+1];
      end
      cnt_r[WORD_BITS-1] <= '0;
    end else if (cmd.out_load) begin
      n_r    <= '0;
      drop_r <= 1'b0;
    end
  end

  always_comb begin
    cons_nxt = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      cons_nxt[b] = ({cnt_r[b], 1'b0} >= {1'b0, n_r});
    end
  end

  assign mul_a = cmd.fin_start ? n_r : cnt_r[0];
  assign mul_b = cmd.fin_start ? (n_r - NW'(1)) : (n_r - cnt_r[0]);

  always_ff @(posedge clk) begin
    if (cmd.fin_start || cmd.sum_shift) begin
      prod_r <= (2*NW)'(mul_a) * (2*NW)'(mul_b);
    end
    if (cmd.fin_start) begin
      cons_r <= cons_nxt;
      dist_r <= '0;
    end else if (cmd.acc_en) begin
      dist_r <= dist_r + DENW'(prod_r);
    end
    if (cmd.den_load) begin
      den_r <= DENW'(prod_r[2*NW-1:1]) * DENW'(WORD_BITS);
    end
  end

  assign ge = (rem_r >= dv_r);

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= (REMW'(den_r - dist_r) << 17) + REMW'(den_r);
      dv_r  <= REMW'(den_r) << 17;
      q_r   <= '0;
    end else if (cmd.div_step) begin
      if (ge) begin
        rem_r <= rem_r - dv_r;
      end
      dv_r <= dv_r >> 1;
      q_r  <= {q_r[Q_BITS-2:0], ge};
    end
  end

  assign n_ext = 32'(n_r);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.unity      <= (n_r < NW'(2)) ? UNITY_ONE : q_r;
      out_r.consensus  <= cons_r;
      out_r.word_count <= n_ext[10:0];
      out_r.overflow   <= drop_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign st.out_free = !out_valid_r || !out_stall;
  assign out_valid   = out_valid_r;
  assign out_data    = out_r;

endmodule

>>> src/hamming_unity_majority_bundle_top.sv
// Throughput: one word per cycle while a set is being collected.
// After the last word is taken the input stalls while the finisher runs
//   (pair count, one bit counter per cycle, 17-step divider) and until the result is loaded.
// The result register frees the finisher only once a waiting result is taken.
// Reset: synchronous, active low; clears the bit counters, word count and overflow flag.
`include "assert_macros.svh"

module hamming_unity_majority_bundle_top import hmub_pkg::*; #(
  parameter int WORD_BITS = 64,
  parameter int WORD_LIMIT = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  cmd_t    cmd;
  status_t st;

  hmub_ctrl #(
    .WORD_BITS(WORD_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_word),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  hmub_datapath #(
    .WORD_BITS(WORD_BITS),
    .WORD_LIMIT(WORD_LIMIT)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `ASSERT_NEXT(a_last_goes_busy, in_valid && !in_stall && in_data.last_word, in_stall)
  `ASSERT_NOW(a_load_only_free, cmd.out_load, st.out_free)
  `ASSERT_NEXT(a_load_shows_valid, cmd.out_load, out_valid)
  `ASSERT_NOW(a_no_word_while_busy, cmd.load_word, !in_stall)

endmodule

>>> tb/sv/hamming_unity_majority_bundle_checker.sv
`timescale 1ns / 100ps

module hamming_unity_majority_bundle_checker import hmub_pkg::*; #(
  parameter int WORD_BITS = 64,
  parameter int WORD_LIMIT = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending_count,
  output int        results_checked
);

  localparam logic [63:0] WORD_MASK = {64{1'b1}} >> (64 - WORD_BITS);

  logic [10:0] bit_ones [64];
  logic [10:0] words_taken;
  logic        words_dropped;
  out_item_t   set_results_q [$];

  task automatic clear_counts();
    int b;
    for (b = 0; b < 64; b++) begin
      bit_ones[b] = '0;
    end
    words_taken   = '0;
    words_dropped = 1'b0;
  endtask

  function automatic logic [16:0] mean_similarity_q16(input logic [10:0] n);
    longint unsigned cnt, pairs, den, ham_sum, ones;
    logic [63:0] q;
    int b;
    if (n < 2) begin
      return UNITY_ONE;
    end
    cnt     = n;
    pairs   = cnt * (cnt - 1) / 2;
    den     = WORD_BITS * pairs;
    ham_sum = 0;
    for (b = 0; b < WORD_BITS; b++) begin
      ones = bit_ones[b];
      ham_sum += ones * (cnt - ones);
    end
    q = ((den - ham_sum) * 65536 * 2 + den) / (den * 2);
    return q[16:0];
  endfunction

  function automatic logic [63:0] majority_word(input logic [10:0] n);
    logic [63:0] m;
    int b;
    m = '0;
    for (b = 0; b < WORD_BITS; b++) begin
      if (2 * bit_ones[b] >= n) begin
        m[b] = 1'b1;
      end
    end
    return m;
  endfunction

  task automatic flag_failure(input string what, input out_item_t exp_item,
                              input out_item_t got);
    if (fail_count < 10) begin
      $display("%0t %s: expected unity=%0d consensus=%h count=%0d overflow=%0b",
               $time, what, exp_item.unity, exp_item.consensus, exp_item.word_count,
               exp_item.overflow);
      $display("%0t %s:      got unity=%0d consensus=%h count=%0d overflow=%0b",
               $time, what, got.unity, got.consensus, got.word_count, got.overflow);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin : track
    out_item_t   exp_item;
    logic [63:0] w;
    logic        bad;
    int          b;
    if (!rst_n) begin
      clear_counts();
      set_results_q.delete();
      fail_count      = 0;
      results_checked = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (set_results_q.size() == 0) begin
          flag_failure("result with none pending", '0, out_data);
        end else begin
          exp_item = set_results_q.pop_front();
          results_checked++;
          bad = (out_data.unity !== exp_item.unity) ||
                (out_data.consensus !== exp_item.consensus) ||
                (out_data.word_count !== exp_item.word_count) ||
                (out_data.overflow !== exp_item.overflow);
          if (bad) begin
            flag_failure("result mismatch", exp_item, out_data);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (words_taken < WORD_LIMIT) begin
          w = in_data.word & WORD_MASK;
          for (b = 0; b < WORD_BITS; b++) begin
            if (w[b]) begin
              bit_ones[b] = bit_ones[b] + 1'b1;
            end
          end
          words_taken = words_taken + 1'b1;
        end else begin
          words_dropped = 1'b1;
        end
        if (in_data.last_word) begin
          exp_item.unity      = mean_similarity_q16(words_taken);
          exp_item.consensus  = majority_word(words_taken);
          exp_item.word_count = words_taken;
          exp_item.overflow   = words_dropped;
          set_results_q.push_back(exp_item);
          clear_counts();
        end
      end
    end
    pending_count = set_results_q.size();
  end

endmodule

>>> tb/sv/hamming_unity_majority_bundle_top_tb.sv
`timescale 1ns / 100ps

module hamming_unity_majority_bundle_top_tb;
  import hmub_pkg::*;

  localparam int WORD_BITS    = 64;
  localparam int WORD_LIMIT   = 1024;
  localparam int DRAIN_CYCLES = WORD_BITS + 23 + 40;

  typedef enum int {
    PAT_RANDOM,
    PAT_NEAR,
    PAT_SPARSE,
    PAT_DENSE,
    PAT_SAME,
    PAT_SWING
  } pattern_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int words_sent     = 0;
  int sets_sent      = 0;
  int overflow_sets  = 0;
  int fail_count;
  int pending_count;
  int results_checked;

  hamming_unity_majority_bundle_top #(
    .WORD_BITS(WORD_BITS),
    .WORD_LIMIT(WORD_LIMIT)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  hamming_unity_majority_bundle_checker #(
    .WORD_BITS(WORD_BITS),
    .WORD_LIMIT(WORD_LIMIT)
  ) result_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .pending_count  (pending_count),
    .results_checked(results_checked)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pattern_word(input pattern_t style, input logic [63:0] base,
                                               input int idx);
    logic [63:0] w;
    case (style)
      PAT_NEAR: begin
        w = base ^ (64'd1 << $urandom_range(63));
        if ($urandom_range(1)) begin
          w = w ^ (64'd1 << $urandom_range(63));
        end
      end
      PAT_SPARSE: w = rand64() & rand64() & rand64();
      PAT_DENSE:  w = rand64() | rand64() | rand64();
      PAT_SAME:   w = base;
      PAT_SWING:  w = idx[0] ? ~base : base;
      default:    w = rand64();
    endcase
    return w;
  endfunction

  // enter and leave at a falling edge; hold the item until taken
  task automatic send_word(input logic [63:0] w, input logic lw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{word: w, last_word: lw};
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    @(negedge clk);
    words_sent++;
    if (lw) begin
      sets_sent++;
    end
  endtask

  task automatic run_set(input int nwords, input pattern_t style);
    logic [63:0] base;
    int i;
    base = rand64();
    for (i = 0; i < nwords; i++) begin
      send_word(pattern_word(style, base, i), i == nwords - 1);
    end
    if (nwords > WORD_LIMIT) begin
      overflow_sets++;
    end
  endtask

  task automatic run_random_set();
    int roll;
    int nwords;
    roll = $urandom_range(99);
    if (roll < 70) begin
      nwords = $urandom_range(8, 1);
    end else if (roll < 95) begin
      nwords = $urandom_range(40, 9);
    end else begin
      nwords = $urandom_range(150, 41);
    end
    run_set(nwords, pattern_t'($urandom_range(PAT_SWING)));
  endtask

  initial begin : stimulus
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct  = 13;
    recv_stall_pct = 84;

    send_word({64{1'b1}}, 1'b1);
    send_word(64'd0, 1'b1);
    send_word({32{2'b10}}, 1'b0);
    send_word({32{2'b01}}, 1'b1);
    send_word(64'hDEAD_BEEF_0123_4567, 1'b0);
    send_word(64'hDEAD_BEEF_0123_4567, 1'b1);
    send_word({64{1'b1}}, 1'b0);
    send_word(64'd0, 1'b0);
    send_word(64'd0, 1'b1);
    send_word(64'h0000_FFFF_0000_FFFF, 1'b0);
    send_word(64'hFFFF_0000_FFFF_0000, 1'b0);
    send_word(64'h00FF_00FF_00FF_00FF, 1'b0);
    send_word(64'hFF00_FF00_FF00_FF00, 1'b1);
    send_word({64{1'b1}}, 1'b0);
    send_word(64'd0, 1'b1);
    run_set(5, PAT_RANDOM);

    while (words_sent < 330) begin
      run_random_set();
    end

    send_idle_pct  = 84;
    recv_stall_pct = 13;
    while (words_sent < 660) begin
      run_random_set();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (words_sent < 950) begin
      run_random_set();
    end
    run_set(WORD_LIMIT + 6, PAT_SWING);
    run_set(3, PAT_DENSE);
    in_valid <= 1'b0;

    while (pending_count != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d words in %0d sets (%0d past the word limit), checked %0d results",
             words_sent, sets_sent, overflow_sets, results_checked);
    $display("Idle profiles: sender-light/receiver-heavy, reversed, and none; %0d failures",
             fail_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #12_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/hmub_pkg.sv
src/hmub_ctrl.sv
src/hmub_datapath.sv
src/hamming_unity_majority_bundle_top.sv
tb/sv/hamming_unity_majority_bundle_checker.sv
tb/sv/hamming_unity_majority_bundle_top_tb.sv
